// ===== rtl/pcmrb_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the PCM overwrite ring buffer.
// No dependencies; every other file imports this package.
package pcmrb_pkg;

  localparam int unsigned CAP_W    = 11;
  localparam int unsigned SAMPLE_W = 32;
  localparam int unsigned TOT_W    = 64;

  typedef enum logic [1:0] {
    MODE_WRITE = 2'd0,
    MODE_READ  = 2'd1,
    MODE_CLEAR = 2'd2,
    MODE_NOP   = 2'd3
  } pcmrb_mode_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_READ = 1'b1
  } pcmrb_state_e;

  typedef struct packed {
    pcmrb_mode_e                 mode;
    logic signed [SAMPLE_W-1:0] sample_in;
    logic                        last_of_block;
  } pcmrb_in_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_out;
    logic                        sample_valid;
    logic                        write_taken;
    logic [CAP_W-1:0]            fill_level;
    logic [CAP_W-1:0]            free_slots;
    logic [CAP_W-1:0]            high_mark;
    logic [CAP_W-1:0]            low_mark;
    logic [TOT_W-1:0]            dropped_total;
    logic [TOT_W-1:0]            written_total;
    logic [TOT_W-1:0]            read_total;
  } pcmrb_out_t;

  // Status after one item, as computed by the pointer and statistics core
  typedef struct packed {
    logic             sample_valid;
    logic             write_taken;
    logic [CAP_W-1:0] fill_level;
    logic [CAP_W-1:0] free_slots;
    logic [CAP_W-1:0] high_mark;
    logic [CAP_W-1:0] low_mark;
    logic [TOT_W-1:0] dropped_total;
    logic [TOT_W-1:0] written_total;
    logic [TOT_W-1:0] read_total;
  } pcmrb_status_t;

  typedef struct packed {
    logic wr;
    logic rd;
  } pcmrb_mem_req_t;

endpackage

// ===== rtl/pcmrb_mem.sv =====
`timescale 1ns / 1ps
// Single-port sample store with registered read data.
// Depends on pcmrb_pkg for the sample width.
module pcmrb_mem #(
  parameter int unsigned DEPTH = 1024
) (
  input  logic                                 clk_i,
  input  pcmrb_pkg::pcmrb_mem_req_t            req_i,
  input  logic [$clog2(DEPTH)-1:0]             addr_i,
  input  logic signed [pcmrb_pkg::SAMPLE_W-1:0] wdata_i,
  output logic signed [pcmrb_pkg::SAMPLE_W-1:0] rdata_o
);
  import pcmrb_pkg::*;

  logic signed [SAMPLE_W-1:0] store_q [DEPTH];
  logic signed [SAMPLE_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr) begin
      store_q[addr_i] <= wdata_i;
    end
    if (req_i.rd) begin
      rdata_q <= store_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/pcmrb_core.sv =====
`timescale 1ns / 1ps
// Pointer, fill count, watermark and total registers of the ring buffer;
// issues the store access for each item. Depends on pcmrb_pkg.
module pcmrb_core #(
  parameter int unsigned DEPTH = 1024
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [pcmrb_pkg::CAP_W-1:0]       cfg_wdata_i,
  input  logic                              take_i,
  input  pcmrb_pkg::pcmrb_in_t              item_i,
  output pcmrb_pkg::pcmrb_mem_req_t         mem_req_o,
  output logic [$clog2(DEPTH)-1:0]          mem_addr_o,
  output pcmrb_pkg::pcmrb_status_t          status_o
);
  import pcmrb_pkg::*;

  localparam int unsigned AW        = $clog2(DEPTH);
  localparam int unsigned SW        = ((AW > CAP_W) ? AW : CAP_W) + 1;
  localparam int unsigned CAP_LIMIT = (DEPTH > 2047) ? 2047 : DEPTH;

  logic [CAP_W-1:0] capacity_q;
  logic [AW-1:0]    oldest_q, oldest_d;
  logic [CAP_W-1:0] held_q, held_d;
  logic [CAP_W-1:0] peak_q, peak_d;
  logic [CAP_W-1:0] trough_q, trough_d;
  logic [TOT_W-1:0] drop_q, drop_d;
  logic [TOT_W-1:0] stored_q, stored_d;
  logic [TOT_W-1:0] popped_q, popped_d;

  logic [CAP_W-1:0] cap;
  logic [SW-1:0]    adv_sum;
  logic [AW-1:0]    oldest_adv;
  logic [AW-1:0]    oldest_w;
  logic [CAP_W-1:0] held_w;
  logic [SW-1:0]    tail_sum;
  logic             mark;
  logic             popped;
  logic             taken;

  // Effective capacity saturates at the store depth, and at 2047 at most
  assign cap = (capacity_q > CAP_W'(CAP_LIMIT)) ? CAP_W'(CAP_LIMIT) : capacity_q;

  assign adv_sum    = SW'(oldest_q) + SW'(1);
  assign oldest_adv = (adv_sum >= SW'(cap)) ? '0 : adv_sum[AW-1:0];

  always_comb begin
    oldest_d   = oldest_q;
    held_d     = held_q;
    drop_d     = drop_q;
    stored_d   = stored_q;
    popped_d   = popped_q;
    peak_d     = peak_q;
    trough_d   = trough_q;
    oldest_w   = oldest_q;
    held_w     = held_q;
    tail_sum   = '0;
    mark       = 1'b0;
    popped     = 1'b0;
    taken      = 1'b0;
    mem_req_o  = '0;
    mem_addr_o = oldest_q;

    case (item_i.mode)
      MODE_WRITE: begin
        if (cap != '0) begin
          // Full ring: drop the oldest sample first
          if (held_q >= cap) begin
            oldest_w = oldest_adv;
            held_w   = held_q - CAP_W'(1);
            drop_d   = drop_q + TOT_W'(1);
          end
          tail_sum = SW'(oldest_w) + SW'(held_w);
          if (tail_sum >= SW'(cap)) begin
            tail_sum = tail_sum - SW'(cap);
          end
          mem_req_o.wr = 1'b1;
          mem_addr_o   = tail_sum[AW-1:0];
          oldest_d     = oldest_w;
          held_d       = held_w + CAP_W'(1);
          stored_d     = stored_q + TOT_W'(1);
          taken        = 1'b1;
          mark         = item_i.last_of_block;
        end
      end
      MODE_READ: begin
        if (held_q != '0 && cap != '0) begin
          mem_req_o.rd = 1'b1;
          oldest_d     = oldest_adv;
          held_d       = held_q - CAP_W'(1);
          popped_d     = popped_q + TOT_W'(1);
          popped       = 1'b1;
        end
        mark = item_i.last_of_block;
      end
      MODE_CLEAR: begin
        oldest_d = '0;
        held_d   = '0;
        drop_d   = '0;
        stored_d = '0;
        popped_d = '0;
        peak_d   = '0;
        trough_d = '0;
      end
      default: begin
      end
    endcase

    if (mark) begin
      if (held_d > peak_q) begin
        peak_d = held_d;
      end
      if (held_d != '0 && (trough_q == '0 || held_d < trough_q)) begin
        trough_d = held_d;
      end
    end
  end

  always_comb begin
    status_o               = '0;
    status_o.sample_valid  = popped;
    status_o.write_taken   = taken;
    status_o.fill_level    = held_d;
    status_o.free_slots    = (held_d <= cap) ? (cap - held_d) : '0;
    status_o.high_mark     = peak_d;
    status_o.low_mark      = trough_d;
    status_o.dropped_total = drop_d;
    status_o.written_total = stored_d;
    status_o.read_total    = popped_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= CAP_W'(CAP_LIMIT);
      oldest_q   <= '0;
      held_q     <= '0;
      peak_q     <= '0;
      trough_q   <= '0;
      drop_q     <= '0;
      stored_q   <= '0;
      popped_q   <= '0;
    end else if (cfg_we_i) begin
      // New capacity: clear contents and statistics
      capacity_q <= cfg_wdata_i;
      oldest_q   <= '0;
      held_q     <= '0;
      peak_q     <= '0;
      trough_q   <= '0;
      drop_q     <= '0;
      stored_q   <= '0;
      popped_q   <= '0;
    end else if (take_i) begin
      oldest_q <= oldest_d;
      held_q   <= held_d;
      peak_q   <= peak_d;
      trough_q <= trough_d;
      drop_q   <= drop_d;
      stored_q <= stored_d;
      popped_q <= popped_d;
    end
  end

endmodule

// ===== rtl/pcm_overwrite_ring_buffer.sv =====
`timescale 1ns / 1ps
// Top level of the PCM overwrite ring buffer: handshake control and result
// register around pcmrb_core and pcmrb_mem. Depends on pcmrb_pkg.
//
// Overwrite-oldest FIFO of signed 32-bit samples held in a single-port
// memory of DEPTH entries. Each item (write, read, clear, no-op) gives one
// result carrying fill level, free slots, watermarks and 64-bit totals. A
// popping read passes through ST_READ, as the sample memory's read data is
// registered; other items load the output register directly. A new item is
// taken once the previous result is in the output register and that register
// is empty or being drained. Writing the capacity register clears pointers,
// fill, watermarks and totals at once; there is no clearing pass after reset.
module pcm_overwrite_ring_buffer #(
  parameter int unsigned DEPTH = 1024
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [pcmrb_pkg::CAP_W-1:0] cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  pcmrb_pkg::pcmrb_in_t        in_item_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output pcmrb_pkg::pcmrb_out_t       out_item_o
);
  import pcmrb_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);

  pcmrb_state_e   state_q, state_d;
  pcmrb_mem_req_t mem_req;
  logic [AW-1:0]  mem_addr;
  logic signed [SAMPLE_W-1:0] mem_rdata;
  pcmrb_status_t  status;
  pcmrb_out_t     out_q, out_d;
  logic           out_valid_q, out_valid_d;
  logic           take;
  logic           load_status;
  logic           load_sample;

  pcmrb_core #(
    .DEPTH(DEPTH)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .take_i     (take),
    .item_i     (in_item_i),
    .mem_req_o  (mem_req),
    .mem_addr_o (mem_addr),
    .status_o   (status)
  );

  pcmrb_mem #(
    .DEPTH(DEPTH)
  ) u_mem (
    .clk_i  (clk_i),
    .req_i  (take ? mem_req : '0),
    .addr_i (mem_addr),
    .wdata_i(in_item_i.sample_in),
    .rdata_o(mem_rdata)
  );

  assign in_stall_o = !(state_q == ST_IDLE && (!out_valid_q || !out_stall_i));
  assign take       = in_valid_i && !in_stall_o;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (take && status.sample_valid) begin
          state_d = ST_READ;
        end
      end
      ST_READ: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs of the state machine
  always_comb begin
    load_status = 1'b0;
    load_sample = 1'b0;
    unique case (state_q)
      ST_IDLE: load_status = take;
      ST_READ: load_sample = 1'b1;
      default: begin
      end
    endcase
  end

  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (load_status) begin
      out_d.sample_out    = '0;
      out_d.sample_valid  = status.sample_valid;
      out_d.write_taken   = status.write_taken;
      out_d.fill_level    = status.fill_level;
      out_d.free_slots    = status.free_slots;
      out_d.high_mark     = status.high_mark;
      out_d.low_mark      = status.low_mark;
      out_d.dropped_total = status.dropped_total;
      out_d.written_total = status.written_total;
      out_d.read_total    = status.read_total;
      // Hold back a popping read until the memory data arrives
      out_valid_d         = !status.sample_valid;
    end
    if (load_sample) begin
      out_d.sample_out = mem_rdata;
      out_valid_d      = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule
